// ----- hw/rtl/tic_lookup_pkg.sv -----
// Package for the timed interval cursor lookup block.
// Holds the beat structs, mode codes and the FSM state type.
// No dependencies.
package ticl_pkg;

   localparam int TableDepthDefault = 1024;
   localparam int TimeW = 63;
   localparam int IdxW = 10;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [TimeW-1:0] interval_begin;
      logic [TimeW-1:0] interval_end;
      logic [TimeW-1:0] query_time;
   } req_type;

   typedef struct packed {
      logic            active;
      logic [IdxW-1:0] entry_index;
      logic            table_full;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/timed_interval_cursor_lookup.sv -----
// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_stall
// rsp      out        rsp_type  rsp_valid / rsp_stall
//
// Clear, append and unused modes go from accept straight to finish.
// A query walks the cursor between accept and finish over k entries:
// each visit is a read of the begin/end memories, then a compare.
// Reset clears the count, cursor and control; the memories are not cleared.
// A finished beat waits in the output register; a new beat is accepted
// meanwhile and its result waits in the finish state while rsp_stall is high.
// Uses ticl_pkg.
module timed_interval_cursor_lookup
   import ticl_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int CW   = CNTW + 1;   // signed cursor, -1 .. count

   state_type state_ff, state_in;

   logic [CNTW-1:0]  count_ff;
   logic [CW-1:0]    cursor_ff;
   logic [TimeW-1:0] time_ff;
   logic             back_ff;
   rsp_type          res_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [TimeW-1:0] begin_mem [TABLE_DEPTH];
   logic [TimeW-1:0] end_mem   [TABLE_DEPTH];
   logic [TimeW-1:0] begin_rd_ff;
   logic [TimeW-1:0] end_rd_ff;

   // control decode
   logic accept, rd_en, out_free, out_load;

   // datapath helpers
   logic [CW-1:0]        cnt_ext;
   logic                 cur_neg, cur_ge;
   logic [CW-1:0]        clamped;
   logic                 table_is_full;
   logic                 wr_en;
   logic                 begin_gt, end_lt;
   logic                 chk_back, chk_fwd, chk_last;
   logic [CW-1:0]        cur_dec, cur_inc, cur_next;
   logic [CW+IdxW-1:0]   cur_idx_ext;
   logic [CNTW+IdxW-1:0] slot_idx_ext;
   rsp_type              chk_res;
   rsp_type              acc_res;

   assign cnt_ext       = {1'b0, count_ff};
   assign cur_neg       = cursor_ff[CW-1];
   assign cur_ge        = !cur_neg && (cursor_ff >= cnt_ext);
   assign clamped       = cur_ge ? (cnt_ext - CW'(1)) : (cur_neg ? '0 : cursor_ff);
   assign table_is_full = (count_ff == CNTW'(TABLE_DEPTH));
   assign wr_en         = accept && (req_data.mode == MODE_APPEND) && !table_is_full;

   assign begin_gt = begin_rd_ff > time_ff;
   assign end_lt   = end_rd_ff < time_ff;
   assign cur_dec  = cursor_ff - CW'(1);
   assign cur_inc  = cursor_ff + CW'(1);
   assign chk_back = back_ff && begin_gt;
   assign chk_fwd  = !chk_back && end_lt;
   assign cur_next = chk_back ? cur_dec : (chk_fwd ? cur_inc : cursor_ff);

   // walk ends when the cursor falls off either end or settles
   always_comb begin
      if (chk_back) begin
         chk_last = (cursor_ff == '0);
      end else if (chk_fwd) begin
         chk_last = (cur_inc == cnt_ext);
      end else begin
         chk_last = 1'b1;
      end
   end

   assign cur_idx_ext  = {{IdxW{1'b0}}, cursor_ff};
   assign slot_idx_ext = {{IdxW{1'b0}}, count_ff};

   always_comb begin
      chk_res = '0;
      if (!chk_back && !chk_fwd) begin
         chk_res.active      = !begin_gt && !end_lt;
         chk_res.entry_index = cur_idx_ext[IdxW-1:0];
      end
   end

   // result of a beat that needs no table walk
   always_comb begin
      acc_res = '0;
      if (req_data.mode == MODE_APPEND) begin
         if (table_is_full) begin
            acc_res.table_full = 1'b1;
         end else begin
            acc_res.entry_index = slot_idx_ext[IdxW-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == MODE_QUERY && count_ff != '0) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: state_in = chk_last ? ST_FINISH : ST_READ;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != ST_IDLE);
      accept    = (state_ff == ST_IDLE) && req_valid;
      rd_en     = (state_ff == ST_READ);
      out_load  = (state_ff == ST_FINISH) && out_free;
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            case (req_data.mode)
               MODE_CLEAR: begin
                  count_ff  <= '0;
                  cursor_ff <= '0;
               end
               MODE_APPEND: begin
                  if (!table_is_full) begin
                     count_ff <= count_ff + CNTW'(1);
                  end
               end
               MODE_QUERY: begin
                  if (count_ff != '0) begin
                     cursor_ff <= clamped;
                  end
               end
               default: ;
            endcase
         end else if (state_ff == ST_CHECK) begin
            cursor_ff <= cur_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         time_ff <= req_data.query_time;
         back_ff <= 1'b1;
         res_ff  <= acc_res;
      end else if (state_ff == ST_CHECK) begin
         back_ff <= chk_back;
         res_ff  <= chk_res;
      end
      if (out_load) begin
         rsp_ff <= res_ff;
      end
   end

   // interval memories, one write and one read port each
   always_ff @(posedge clock) begin
      if (wr_en) begin
         begin_mem[count_ff[AW-1:0]] <= req_data.interval_begin;
         end_mem[count_ff[AW-1:0]]   <= req_data.interval_end;
      end
      if (rd_en) begin
         begin_rd_ff <= begin_mem[cursor_ff[AW-1:0]];
         end_rd_ff   <= end_mem[cursor_ff[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      !cursor_ff[CW-1] |-> cursor_ff <= cnt_ext)
      else $error("cursor beyond entry count");

   a_read_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> (!cursor_ff[CW-1] && cursor_ff < cnt_ext))
      else $error("memory read outside written entries");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted beat left no work");

endmodule
